// ===== hdl/ses_pkg.sv =====
package ses_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_COEFF = 1'd1;

	// Reset value of both coefficients, about 0.01 in Q0.16.
	localparam logic [CFG_DATA_W-1:0] COEFF_RESET = 16'd655;

	// One input beat.
	typedef struct packed {
		logic signed [15:0] psi_re;
		logic signed [15:0] psi_im;
		logic signed [15:0] potential;
		logic               last_sample;
	} in_beat_t;

	// One output beat.
	typedef struct packed {
		logic signed [15:0] new_re;
		logic signed [15:0] new_im;
		logic [31:0]        density;
		logic               end_of_grid;
	} out_beat_t;

	// Source of the result register.
	typedef enum logic [1:0] {
		SEL_CALC,
		SEL_CENTER,
		SEL_INPUT
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     cap_in;
		logic     mul1_en;
		logic     mul2_en;
		logic     res_en;
		res_sel_t res_sel;
		logic     res_end;
		logic     sq_en;
		logic     out_load;
		logic     shift;
	} ses_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_last;
	} ses_status_t;

endpackage

// ===== hdl/ses_ctrl.sv =====
module ses_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ses_pkg::ses_status_t status,
	output ses_pkg::ses_cmd_t    cmd
);
	import ses_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CALC,
		ST_EDGE,
		ST_LASTX,
		ST_SQ,
		ST_LOAD,
		ST_SHIFT
	} state_t;

	state_t state_q;
	logic   center_valid_q;
	logic   center_is_edge_q;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   load_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign load_ok   = (state_q == ST_LOAD) && (!out_valid_q || out_ready);

	// Datapath commands follow the state.
	always_comb begin
		cmd          = '0;
		cmd.res_sel  = SEL_CALC;
		cmd.cap_in   = accept;
		cmd.mul1_en  = (state_q == ST_MUL1);
		cmd.mul2_en  = (state_q == ST_MUL2);
		cmd.sq_en    = (state_q == ST_SQ);
		cmd.out_load = load_ok;
		cmd.shift    = (state_q == ST_SHIFT);
		case (state_q)
			ST_CALC: begin
				cmd.res_en  = 1'b1;
				cmd.res_sel = SEL_CALC;
			end
			ST_EDGE: begin
				cmd.res_en  = 1'b1;
				cmd.res_sel = SEL_CENTER;
			end
			ST_LASTX: begin
				cmd.res_en  = 1'b1;
				cmd.res_sel = SEL_INPUT;
				cmd.res_end = 1'b1;
			end
			default: begin
				cmd.res_en = 1'b0;
			end
		endcase
	end

	// State sequencing, stencil flags and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			center_valid_q   <= 1'b0;
			center_is_edge_q <= 1'b0;
			last_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= status.in_last;
						if (center_valid_q) begin
							state_q <= center_is_edge_q ? ST_EDGE : ST_MUL1;
						end else if (status.in_last) begin
							state_q <= ST_LASTX;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_SQ;
				ST_EDGE: state_q <= ST_SQ;
				ST_LASTX: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (load_ok) begin
						if (last_q && center_valid_q) begin
							// Held sample is out; the last sample follows unchanged.
							center_valid_q   <= 1'b0;
							center_is_edge_q <= 1'b0;
							state_q          <= ST_LASTX;
						end else if (last_q) begin
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					center_is_edge_q <= !center_valid_q;
					center_valid_q   <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ses_datapath.sv =====
module ses_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ses_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ses_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ses_pkg::in_beat_t            in_data,
	output ses_pkg::out_beat_t           out_data,
	input  ses_pkg::ses_cmd_t            cmd,
	output ses_pkg::ses_status_t         status
);
	import ses_pkg::*;

	localparam int Q_SHIFT = 24;
	localparam int SUM_W = 50;

	logic [15:0]        time_step_q;
	logic [15:0]        diffusion_coeff_q;
	in_beat_t           x_q;
	logic signed [15:0] left_re_q, left_im_q;
	logic signed [15:0] center_re_q, center_im_q, center_pot_q;
	logic signed [32:0] dtv_s1;
	logic signed [17:0] lap_re_s1, lap_im_s1;
	logic signed [48:0] pa_s2, pb_s2;
	logic signed [34:0] pc_s2, pd_s2;
	logic signed [SUM_W-1:0] sum_re, sum_im;
	logic signed [15:0] calc_re, calc_im;
	logic signed [15:0] res_re_q, res_im_q;
	logic               res_end_q;
	logic signed [31:0] sq_re_s3, sq_im_s3;
	out_beat_t          out_q;

	// Drop 24 fraction bits (floor) and clamp to the 16-bit range.
	function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-Q_SHIFT-1:0] q;
		q = v[SUM_W-1:Q_SHIFT];
		if (q > 26'sd32767) begin
			sat16 = 16'sh7FFF;
		end else if (q < -26'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = q[15:0];
		end
	endfunction

	assign status.in_last = in_data.last_sample;
	assign out_data       = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q       <= COEFF_RESET;
			diffusion_coeff_q <= COEFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data;
				REG_DIFFUSION_COEFF: diffusion_coeff_q <= cfg_data;
				default: time_step_q <= time_step_q;
			endcase
		end
	end

	// Stencil samples: the incoming beat, the held center and its left neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_re_q    <= '0;
			left_im_q    <= '0;
			center_re_q  <= '0;
			center_im_q  <= '0;
			center_pot_q <= '0;
		end else if (cmd.shift) begin
			left_re_q    <= center_re_q;
			left_im_q    <= center_im_q;
			center_re_q  <= x_q.psi_re;
			center_im_q  <= x_q.psi_im;
			center_pot_q <= x_q.potential;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			x_q <= in_data;
		end
	end

	// Stage 1: dt times potential, and the discrete Laplacian.
	always_ff @(posedge clk) begin
		if (cmd.mul1_en) begin
			dtv_s1    <= $signed({1'b0, time_step_q}) * center_pot_q;
			lap_re_s1 <= 18'(x_q.psi_re) + 18'(left_re_q) - (18'(center_re_q) <<< 1);
			lap_im_s1 <= 18'(x_q.psi_im) + 18'(left_im_q) - (18'(center_im_q) <<< 1);
		end
	end

	// Stage 2: the four cross products.
	always_ff @(posedge clk) begin
		if (cmd.mul2_en) begin
			pa_s2 <= dtv_s1 * 49'(center_im_q);
			pb_s2 <= dtv_s1 * 49'(center_re_q);
			pc_s2 <= $signed({1'b0, diffusion_coeff_q}) * lap_im_s1;
			pd_s2 <= $signed({1'b0, diffusion_coeff_q}) * lap_re_s1;
		end
	end

	// Sum at 38 fraction bits with half an LSB added for rounding.
	always_comb begin
		sum_re = (SUM_W'(center_re_q) <<< Q_SHIFT) + SUM_W'(pa_s2)
		       - (SUM_W'(pc_s2) <<< 8) + (SUM_W'(1) <<< (Q_SHIFT - 1));
		sum_im = (SUM_W'(center_im_q) <<< Q_SHIFT) - SUM_W'(pb_s2)
		       + (SUM_W'(pd_s2) <<< 8) + (SUM_W'(1) <<< (Q_SHIFT - 1));
		calc_re = sat16(sum_re);
		calc_im = sat16(sum_im);
	end

	// Result register: computed update or a sample passed through.
	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			res_end_q <= cmd.res_end;
			case (cmd.res_sel)
				SEL_CALC: begin
					res_re_q <= calc_re;
					res_im_q <= calc_im;
				end
				SEL_CENTER: begin
					res_re_q <= center_re_q;
					res_im_q <= center_im_q;
				end
				SEL_INPUT: begin
					res_re_q <= x_q.psi_re;
					res_im_q <= x_q.psi_im;
				end
				default: begin
					res_re_q <= calc_re;
					res_im_q <= calc_im;
				end
			endcase
		end
	end

	// Stage 3: squares for the density.
	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_re_s3 <= 32'(res_re_q) * 32'(res_im_q - res_im_q + res_re_q);
			sq_im_s3 <= 32'(res_im_q) * 32'(res_im_q);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.new_re      <= res_re_q;
			out_q.new_im      <= res_im_q;
			out_q.density     <= unsigned'(sq_re_s3) + unsigned'(sq_im_s3);
			out_q.end_of_grid <= res_end_q;
		end
	end

endmodule

// ===== hdl/schrodinger_euler_stencil_step_top.sv =====
// One explicit Euler step of the 1D Schrodinger equation over a streamed grid.
// Input beats carry one complex sample (Q1.14), its potential (Q8.8) and a
// last_sample flag; output beats carry the updated sample, its density and
// end_of_grid. Results lag one sample: the result for a sample leaves once
// its right neighbor has arrived, and the last sample yields two beats.
// The first and last samples of a grid pass through unchanged.
// The configuration port (cfg_we, cfg_index, cfg_data) sets dt and dt/dx^2.
// The user must write it only while the block is idle; it is not enforced.
// An interior result passes through MUL1, MUL2, CALC, SQ and LOAD before
// out_valid rises; a boundary result goes through EDGE or LASTX, SQ and LOAD.
// One item is worked at a time through a shared multiply, round and square
// sequence, and in_ready stays low from the taking of a sample until the
// sequencer is back in idle: after SHIFT for a first sample, after LOAD and
// SHIFT for one that completes a stencil, and after the extra pass-through
// beat of a last sample (LASTX, SQ and LOAD).
// A single output register holds the result while the receiver stalls; the
// block still accepts the next beat and waits only when it must load a new
// result. Reset restores both coefficients to 655 and drops the held sample.
module schrodinger_euler_stencil_step_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ses_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ses_pkg::out_beat_t            out_data,
	input  logic                          cfg_we,
	input  logic [ses_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ses_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ses_pkg::*;

	ses_cmd_t    cmd;
	ses_status_t status;

	// Sequencer.
	ses_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and sample storage.
	ses_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
